// File: rtl/core/region_bump_frame_allocator_defines.svh
// Assertion macros used by the frame allocator sequencer.
`ifndef REGION_BUMP_FRAME_ALLOCATOR_DEFINES_SVH
`define REGION_BUMP_FRAME_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define RBFA_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("frame allocator check failed");
`define RBFA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("frame allocator sequencing check failed");
`else
`define RBFA_ASSERT_IMPL(lbl, ante, cons)
`define RBFA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/core/rbfa_pkg.sv
// Types, constants and codes shared by the frame allocator modules.
package rbfa_pkg;
	localparam int unsigned MAX_REGIONS_DEF = 16;
	localparam int unsigned ADDR_W     = 64;
	localparam int unsigned LEN_W      = 64;
	localparam int unsigned TYPE_W     = 8;
	localparam int unsigned IDX_W      = 4;
	localparam int unsigned CNT_W      = 5;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 8;

	localparam logic [ADDR_W-1:0] FRAME_BYTES = 64'd4096;
	localparam logic [TYPE_W-1:0] USED_MARK   = 8'hA9;

	typedef enum logic [1:0] {
		MODE_LOAD,
		MODE_INIT,
		MODE_ALLOC,
		MODE_NOP
	} mode_t;

	typedef enum logic [1:0] {
		ST_GIVEN,
		ST_NOINIT,
		ST_OOM,
		ST_DONE
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_REGION_COUNT,
		CFG_USABLE_TYPE
	} cfg_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN_INIT,
		S_SCAN_ALLOC,
		S_CHK_ZERO,
		S_CHK_LEN,
		S_RESP
	} ctl_state_t;

	typedef struct packed {
		logic    load_wr;
		logic    init_clear;
		logic    set_init;
		logic    alloc_start;
		logic    scan_start;
		logic    scan_step;
		logic    take;
		logic    skip;
		logic    give;
		logic    set_result;
		status_t result;
		logic    push;
	} rbfa_cmd_t;

	typedef struct packed {
		logic initialized;
		logic zero_base;
		logic len_ge;
		logic scan_hit;
		logic scan_miss;
		logic scans_over;
		logic out_free;
	} rbfa_sts_t;
endpackage

// File: rtl/core/rbfa_ifs.sv
// Request, response and configuration channel interfaces of the frame allocator.
interface rbfa_req_if;
	import rbfa_pkg::*;
	logic                valid;
	logic                ready;
	mode_t               mode;
	logic [IDX_W-1:0]    entry_index;
	logic [ADDR_W-1:0]   entry_base;
	logic [LEN_W-1:0]    entry_length;
	logic [TYPE_W-1:0]   entry_type;

	modport source (output valid, mode, entry_index, entry_base, entry_length, entry_type,
		input ready);
	modport sink (input valid, mode, entry_index, entry_base, entry_length, entry_type,
		output ready);
endinterface

interface rbfa_rsp_if;
	import rbfa_pkg::*;
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] frame_address;
	status_t           status;

	modport source (output valid, frame_address, status, input ready);
	modport sink (input valid, frame_address, status, output ready);
endinterface

interface rbfa_cfg_if;
	import rbfa_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/rbfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rbfa_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

// File: rtl/core/rbfa_ctrl.sv
// Sequencer of the frame allocator: decodes items and steps the scan and bump.
`include "region_bump_frame_allocator_defines.svh"
module rbfa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  rbfa_pkg::mode_t    req_mode,
	output logic               req_ready,
	input  rbfa_pkg::rbfa_sts_t sts,
	output rbfa_pkg::rbfa_cmd_t cmd
);
	import rbfa_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt  = state_q;
		cmd        = '0;
		cmd.result = ST_DONE;
		req_ready  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					unique case (req_mode)
						MODE_LOAD: begin
							cmd.load_wr    = 1'b1;
							cmd.set_result = 1'b1;
							cmd.result     = ST_DONE;
							state_nxt      = S_RESP;
						end
						MODE_INIT: begin
							cmd.init_clear = 1'b1;
							cmd.scan_start = 1'b1;
							state_nxt      = S_SCAN_INIT;
						end
						MODE_ALLOC: begin
							if (!sts.initialized) begin
								cmd.set_result = 1'b1;
								cmd.result     = ST_NOINIT;
								state_nxt      = S_RESP;
							end else begin
								cmd.alloc_start = 1'b1;
								state_nxt       = S_CHK_ZERO;
							end
						end
						MODE_NOP: begin
							cmd.set_result = 1'b1;
							cmd.result     = ST_DONE;
							state_nxt      = S_RESP;
						end
						default: begin
							state_nxt = S_IDLE;
						end
					endcase
				end
			end
			S_SCAN_INIT: begin
				if (sts.scan_hit) begin
					cmd.take       = 1'b1;
					cmd.set_init   = 1'b1;
					cmd.set_result = 1'b1;
					cmd.result     = ST_DONE;
					state_nxt      = S_RESP;
				end else if (sts.scan_miss) begin
					cmd.set_result = 1'b1;
					cmd.result     = ST_OOM;
					state_nxt      = S_RESP;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_SCAN_ALLOC: begin
				if (sts.scan_hit) begin
					cmd.take  = 1'b1;
					state_nxt = S_CHK_ZERO;
				end else if (sts.scan_miss) begin
					cmd.set_result = 1'b1;
					cmd.result     = ST_OOM;
					state_nxt      = S_RESP;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_CHK_ZERO: begin
				// A region that starts at address zero never hands out its first page.
				if (sts.zero_base && sts.len_ge) begin
					cmd.skip = 1'b1;
				end
				state_nxt = S_CHK_LEN;
			end
			S_CHK_LEN: begin
				if (sts.len_ge && !sts.zero_base) begin
					cmd.give       = 1'b1;
					cmd.set_result = 1'b1;
					cmd.result     = ST_GIVEN;
					state_nxt      = S_RESP;
				end else if (sts.scans_over) begin
					cmd.set_result = 1'b1;
					cmd.result     = ST_OOM;
					state_nxt      = S_RESP;
				end else begin
					cmd.scan_start = 1'b1;
					state_nxt      = S_SCAN_ALLOC;
				end
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.push  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	`RBFA_ASSERT_IMPL(a_give_needs_init, cmd.give, sts.initialized)
	`RBFA_ASSERT_IMPL(a_zero_page_skipped, state_q == S_CHK_LEN, !(sts.zero_base && sts.len_ge))
	`RBFA_ASSERT_NEXT(a_resp_drains, (state_q == S_RESP) && sts.out_free, state_q == S_IDLE)
endmodule

// File: rtl/core/rbfa_datapath.sv
// Datapath of the frame allocator: region table, current region, scan and output register.
module rbfa_datapath #(
	parameter int unsigned MAX_REGIONS = rbfa_pkg::MAX_REGIONS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [rbfa_pkg::IDX_W-1:0]  entry_index,
	input  logic [rbfa_pkg::ADDR_W-1:0] entry_base,
	input  logic [rbfa_pkg::LEN_W-1:0]  entry_length,
	input  logic [rbfa_pkg::TYPE_W-1:0] entry_type,
	rbfa_rsp_if.source                  rsp,
	rbfa_cfg_if.sink                    cfg,
	input  rbfa_pkg::rbfa_cmd_t         cmd,
	output rbfa_pkg::rbfa_sts_t         sts
);
	import rbfa_pkg::*;

	localparam int unsigned AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int unsigned CW = $clog2(MAX_REGIONS + 1);
	localparam int unsigned SW = $clog2(MAX_REGIONS + 2);
	localparam int unsigned EW = TYPE_W + LEN_W + ADDR_W;
	localparam logic [8:0]  MAXR9 = 9'(MAX_REGIONS);

	logic [CNT_W-1:0]  region_count_q;
	logic [TYPE_W-1:0] usable_type_q;
	logic [ADDR_W-1:0] cur_base_q;
	logic [LEN_W-1:0]  cur_len_q;
	logic              init_q;
	logic [CW-1:0]     idx_q;
	logic              rd_vld_s1;
	logic [AW-1:0]     rd_idx_s1;
	logic [SW-1:0]     scans_q;
	logic [ADDR_W-1:0] pend_addr_q;
	status_t           pend_status_q;
	logic [ADDR_W-1:0] out_addr_q;
	status_t           out_status_q;
	logic              out_valid_q;

	logic [8:0]        rc9;
	logic [8:0]        n_eff9;
	logic [CW-1:0]     n_eff;
	logic              issue;
	logic [8:0]        ldx9;
	logic              load_ok;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [EW-1:0]     wr_data;
	logic [EW-1:0]     rd_data;
	logic [ADDR_W-1:0] rd_base;
	logic [LEN_W-1:0]  rd_len;
	logic [TYPE_W-1:0] rd_type;

	// Counts above the table depth scan the whole table.
	assign rc9    = 9'(region_count_q);
	assign n_eff9 = (rc9 > MAXR9) ? MAXR9 : rc9;
	assign n_eff  = n_eff9[CW-1:0];
	assign issue  = cmd.scan_step && (idx_q < n_eff);

	assign ldx9    = 9'(entry_index);
	assign load_ok = cmd.load_wr && (ldx9 < MAXR9);

	assign rd_base = rd_data[ADDR_W-1:0];
	assign rd_len  = rd_data[ADDR_W +: LEN_W];
	assign rd_type = rd_data[ADDR_W+LEN_W +: TYPE_W];

	// Taking a region writes its entry back with the type replaced by the used mark.
	assign wr_en   = load_ok || cmd.take;
	assign wr_addr = cmd.take ? rd_idx_s1 : ldx9[AW-1:0];
	assign wr_data = cmd.take ? {USED_MARK, rd_len, rd_base}
		: {entry_type, entry_length, entry_base};

	rbfa_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_REGIONS)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (issue),
		.rd_addr (idx_q[AW-1:0]),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_count_q <= '0;
			usable_type_q  <= '0;
			cur_base_q     <= '0;
			cur_len_q      <= '0;
			init_q         <= 1'b0;
			idx_q          <= '0;
			rd_vld_s1      <= 1'b0;
			scans_q        <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg.valid) begin
				if (cfg.index == CFG_REGION_COUNT) begin
					region_count_q <= cfg.data[CNT_W-1:0];
				end else if (cfg.index == CFG_USABLE_TYPE) begin
					usable_type_q <= cfg.data;
				end
			end

			priority if (cmd.init_clear) begin
				cur_base_q <= '0;
				cur_len_q  <= '0;
			end else if (cmd.take) begin
				cur_base_q <= rd_base;
				cur_len_q  <= rd_len;
			end else if (cmd.skip || cmd.give) begin
				cur_base_q <= cur_base_q + FRAME_BYTES;
				cur_len_q  <= cur_len_q - FRAME_BYTES;
			end else begin
				cur_base_q <= cur_base_q;
			end

			if (cmd.init_clear) begin
				init_q <= 1'b0;
			end else if (cmd.set_init) begin
				init_q <= 1'b1;
			end

			if (cmd.scan_start) begin
				idx_q     <= '0;
				rd_vld_s1 <= 1'b0;
			end else if (cmd.scan_step) begin
				if (issue) begin
					idx_q <= idx_q + 1'b1;
				end
				rd_vld_s1 <= issue;
			end

			if (cmd.alloc_start) begin
				scans_q <= '0;
			end else if (cmd.scan_start) begin
				scans_q <= scans_q + 1'b1;
			end

			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_idx_s1 <= idx_q[AW-1:0];
		end
		if (cmd.set_result) begin
			pend_status_q <= cmd.result;
			pend_addr_q   <= cmd.give ? cur_base_q : '0;
		end
		if (cmd.push) begin
			out_addr_q   <= pend_addr_q;
			out_status_q <= pend_status_q;
		end
	end

	assign sts.initialized = init_q;
	assign sts.zero_base   = (cur_base_q == '0);
	assign sts.len_ge      = |cur_len_q[LEN_W-1:12];
	assign sts.scan_hit    = rd_vld_s1 && (rd_type == usable_type_q);
	assign sts.scan_miss   = !rd_vld_s1 && (idx_q >= n_eff);
	assign sts.scans_over  = (scans_q > SW'(MAX_REGIONS));
	assign sts.out_free    = !out_valid_q || rsp.ready;

	assign cfg.ready         = 1'b1;
	assign rsp.valid         = out_valid_q;
	assign rsp.frame_address = out_addr_q;
	assign rsp.status        = out_status_q;
endmodule

// File: rtl/core/region_bump_frame_allocator.sv
// Bump allocator of 4096-byte page frames over a table of memory regions. One item is
// worked at a time. A load, an unused mode or an allocate before init goes straight to
// the response state; an allocate first checks for a zero base, then the length of the
// current region. Each rescan reads the table RAM one entry per cycle through its single
// read port, over at most region_count capped at MAX_REGIONS entries. An allocate makes
// at most MAX_REGIONS + 1 rescans before it answers out of memory. The result waits in an
// output register, so the next item is taken while it is unclaimed; the table holds
// MAX_REGIONS entries and a scan that reaches a slot never loaded yields undefined data.
module region_bump_frame_allocator #(
	parameter int unsigned MAX_REGIONS = rbfa_pkg::MAX_REGIONS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	rbfa_req_if.sink   req,
	rbfa_rsp_if.source rsp,
	rbfa_cfg_if.sink   cfg
);
	import rbfa_pkg::*;

	rbfa_cmd_t cmd;
	rbfa_sts_t sts;
	logic      ready;

	rbfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_mode  (req.mode),
		.req_ready (ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rbfa_datapath #(
		.MAX_REGIONS (MAX_REGIONS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.entry_index  (req.entry_index),
		.entry_base   (req.entry_base),
		.entry_length (req.entry_length),
		.entry_type   (req.entry_type),
		.rsp          (rsp),
		.cfg          (cfg),
		.cmd          (cmd),
		.sts          (sts)
	);

	assign req.ready = ready;
endmodule

// File: tb/sv/rbfa_frame_checker.sv
// Watches the frame allocator channels, predicts every response word and compares it.
`timescale 1ns / 100ps

module rbfa_frame_checker (
	input  logic        clk,
	input  logic        arst_n,
	rbfa_req_if         req,
	rbfa_rsp_if         rsp,
	rbfa_cfg_if         cfg,
	output int unsigned mismatches,
	output int unsigned awaiting,
	output int unsigned frames_given,
	output int unsigned oom_answers
);
	import rbfa_pkg::*;

	localparam int unsigned PRINT_CAP = 40;

	typedef struct packed {
		logic [ADDR_W-1:0] frame_address;
		status_t           status;
	} frame_word_t;

	// Shadow copy of the region table and the current region.
	logic [ADDR_W-1:0] table_base [MAX_REGIONS_DEF];
	logic [LEN_W-1:0]  table_len  [MAX_REGIONS_DEF];
	logic [TYPE_W-1:0] table_type [MAX_REGIONS_DEF];
	logic [ADDR_W-1:0] cur_base;
	logic [LEN_W-1:0]  cur_len;
	logic              cur_valid;
	logic [CNT_W-1:0]  scan_limit;
	logic [TYPE_W-1:0] usable_code;

	frame_word_t expected_words [$];
	int unsigned words_checked;

	task automatic report_mismatch(input string what, input logic [63:0] seen,
		input logic [63:0] wanted);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("[%0t] response word %0d: %s is %h, expected %h", $time,
				words_checked, what, seen, wanted);
	endtask

	// Takes the first free region of the scanned part of the table and marks it used.
	function automatic logic claim_region();
		int unsigned span;
		span = (scan_limit > MAX_REGIONS_DEF) ? MAX_REGIONS_DEF : scan_limit;
		for (int unsigned i = 0; i < span; i++) begin
			if (table_type[i] == usable_code) begin
				table_type[i] = USED_MARK;
				cur_base = table_base[i];
				cur_len = table_len[i];
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic frame_word_t predict_frame_word(input mode_t m,
		input logic [IDX_W-1:0] idx, input logic [ADDR_W-1:0] b,
		input logic [LEN_W-1:0] l, input logic [TYPE_W-1:0] t);
		frame_word_t res;
		int unsigned rescans;
		logic spent;
		logic done;
		res.frame_address = '0;
		res.status = ST_DONE;
		case (m)
		MODE_LOAD: begin
			table_base[idx] = b;
			table_len[idx] = l;
			table_type[idx] = t;
		end
		MODE_INIT: begin
			cur_base = '0;
			cur_len = '0;
			cur_valid = 1'b0;
			if (claim_region())
				cur_valid = 1'b1;
			else
				res.status = ST_OOM;
		end
		MODE_ALLOC: begin
			if (!cur_valid) begin
				res.status = ST_NOINIT;
			end else begin
				res.status = ST_OOM;
				rescans = 0;
				done = 1'b0;
				while (!done) begin
					spent = 1'b0;
					// A region at address zero gives up its first page, or is spent if shorter.
					if (cur_base == '0) begin
						if (cur_len < FRAME_BYTES) begin
							spent = 1'b1;
						end else begin
							cur_base = cur_base + FRAME_BYTES;
							cur_len = cur_len - FRAME_BYTES;
						end
					end
					if (spent || cur_len < FRAME_BYTES) begin
						if (rescans > MAX_REGIONS_DEF) begin
							done = 1'b1;
						end else begin
							rescans++;
							if (!claim_region())
								done = 1'b1;
						end
					end else begin
						res.frame_address = cur_base;
						cur_base = cur_base + FRAME_BYTES;
						cur_len = cur_len - FRAME_BYTES;
						res.status = ST_GIVEN;
						done = 1'b1;
					end
				end
			end
		end
		default: begin
		end
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		frame_word_t want;
		if (!arst_n) begin
			expected_words.delete();
			cur_base = '0;
			cur_len = '0;
			cur_valid = 1'b0;
			scan_limit = '0;
			usable_code = '0;
			mismatches = 0;
			words_checked = 0;
			frames_given = 0;
			oom_answers = 0;
			awaiting <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				words_checked++;
				if (expected_words.size() == 0) begin
					report_mismatch("word with nothing expected, frame_address",
						rsp.frame_address, '0);
				end else begin
					want = expected_words.pop_front();
					if (rsp.frame_address !== want.frame_address)
						report_mismatch("frame_address", rsp.frame_address, want.frame_address);
					if (rsp.status !== want.status)
						report_mismatch("status", 64'(rsp.status), 64'(want.status));
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg_reg_t'(cfg.index))
				CFG_REGION_COUNT: begin
					scan_limit = cfg.data[CNT_W-1:0];
				end
				CFG_USABLE_TYPE: begin
					usable_code = cfg.data[TYPE_W-1:0];
				end
				default: begin
				end
				endcase
			end
			if (req.valid && req.ready) begin
				want = predict_frame_word(req.mode, req.entry_index, req.entry_base,
					req.entry_length, req.entry_type);
				if (want.status == ST_GIVEN)
					frames_given++;
				else if (want.status == ST_OOM)
					oom_answers++;
				expected_words.push_back(want);
			end
			awaiting <= expected_words.size();
		end
	end
endmodule

// File: tb/sv/region_bump_frame_allocator_test.sv
// Top of the frame allocator testbench: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module region_bump_frame_allocator_test;
	import rbfa_pkg::*;

	localparam int unsigned STALL_LIMIT = 3000;
	localparam int unsigned PHASE_WORDS = 150;
	localparam int unsigned PHASES      = 10;
	localparam int unsigned HOLD_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n;

	rbfa_req_if req_ch();
	rbfa_rsp_if rsp_ch();
	rbfa_cfg_if cfg_ch();

	int unsigned mismatches;
	int unsigned awaiting;
	int unsigned frames_given;
	int unsigned oom_answers;
	int unsigned mode_tally [4];
	int unsigned settings_used;
	logic [TYPE_W-1:0] usable_now;
	bit sender_idles;

	region_bump_frame_allocator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	rbfa_frame_checker frame_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req_ch),
		.rsp          (rsp_ch),
		.cfg          (cfg_ch),
		.mismatches   (mismatches),
		.awaiting     (awaiting),
		.frames_given (frames_given),
		.oom_answers  (oom_answers)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [ADDR_W-1:0] pick_base();
		logic [ADDR_W-1:0] raw;
		raw = {$urandom, $urandom};
		case ($urandom_range(0, 9))
		0, 1: return '0;
		2: return {52'hF_FFFF_FFFF_FFFF - 52'($urandom_range(0, 3)), 12'h000};
		3, 4: return raw;
		5, 6: return {32'h0, raw[31:12], 12'h000};
		default: return {raw[63:12], 12'h000};
		endcase
	endfunction

	// Mostly a few pages, so that regions run dry and the table is rescanned.
	function automatic logic [LEN_W-1:0] pick_length();
		logic [11:0] tail;
		tail = ($urandom_range(0, 1) != 0) ? 12'($urandom) : 12'h000;
		case ($urandom_range(0, 9))
		0: return '0;
		1: return 64'($urandom_range(1, 4095));
		2: return {$urandom, $urandom};
		3: return '1;
		default: return {44'd0, 8'($urandom_range(1, 6)), tail};
		endcase
	endfunction

	function automatic logic [TYPE_W-1:0] pick_type();
		case ($urandom_range(0, 9))
		0: return USED_MARK;
		1, 2, 3: return 8'($urandom);
		default: return usable_now;
		endcase
	endfunction

	// Entered at a rising edge; returns at the edge where the word is taken.
	task automatic send_word(input mode_t m, input logic [IDX_W-1:0] idx,
		input logic [ADDR_W-1:0] b, input logic [LEN_W-1:0] l, input logic [TYPE_W-1:0] t);
		int unsigned gap;
		gap = sender_idles ? $urandom_range(0, 14) : 0;
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.mode <= m;
		req_ch.entry_index <= idx;
		req_ch.entry_base <= b;
		req_ch.entry_length <= l;
		req_ch.entry_type <= t;
		do @(posedge clk); while (!req_ch.ready);
		mode_tally[int'(m)]++;
	endtask

	task automatic send_bare(input mode_t m);
		send_word(m, 4'($urandom), {$urandom, $urandom}, {$urandom, $urandom}, 8'($urandom));
	endtask

	task automatic send_random_load(input logic [IDX_W-1:0] idx);
		send_word(MODE_LOAD, idx, pick_base(), pick_length(), pick_type());
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (awaiting != 0);
	endtask

	task automatic apply_setting(input logic [CFG_DATA_W-1:0] count_data,
		input logic [CFG_DATA_W-1:0] usable);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= CFG_REGION_COUNT;
		cfg_ch.data <= count_data;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.index <= CFG_USABLE_TYPE;
		cfg_ch.data <= usable;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		usable_now = usable;
		settings_used++;
	endtask

	// A fresh table layout and an init, then a mixed stream dominated by allocations.
	task automatic run_phase(input int unsigned words);
		int unsigned pick;
		int unsigned loads;
		sender_idles = ($urandom_range(0, 3) != 0);
		loads = $urandom_range(1, 16);
		repeat (loads) send_random_load(4'($urandom));
		send_bare(MODE_INIT);
		for (int unsigned n = loads + 1; n < words; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 25)
				send_random_load(4'($urandom));
			else if (pick < 32)
				send_bare(MODE_INIT);
			else if (pick < 94)
				send_bare(MODE_ALLOC);
			else
				send_bare(MODE_NOP);
		end
		drain();
	endtask

	initial begin
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.mode <= MODE_NOP;
		req_ch.entry_index <= '0;
		req_ch.entry_base <= '0;
		req_ch.entry_length <= '0;
		req_ch.entry_type <= '0;
		rsp_ch.ready <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= CFG_REGION_COUNT;
		cfg_ch.data <= '0;
		sender_idles = 1'b1;
		usable_now = '0;
		settings_used = 0;
		for (int i = 0; i < 4; i++)
			mode_tally[i] = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With nothing scanned yet: allocate before init, an unused mode, an init on an empty
		// table and an allocate after that failed init.
		apply_setting(8'h00, 8'h5A);
		send_bare(MODE_ALLOC);
		send_bare(MODE_NOP);
		send_bare(MODE_INIT);
		send_bare(MODE_ALLOC);
		// Short region at zero, a page to skip at zero, a region that wraps past the top,
		// a used entry, a region under one page and a region of full length.
		send_word(MODE_LOAD, 4'd0, 64'd0, 64'd100, usable_now);
		send_word(MODE_LOAD, 4'd1, 64'd0, 64'd12288, usable_now);
		send_word(MODE_LOAD, 4'd2, 64'hFFFF_FFFF_FFFF_E000, 64'd8197, usable_now);
		send_word(MODE_LOAD, 4'd3, '1, '1, USED_MARK);
		send_word(MODE_LOAD, 4'd4, 64'h1234_5000, 64'd4095, usable_now);
		send_word(MODE_LOAD, 4'd5, 64'h8000_0000, '1, 8'h00);
		for (int s = 6; s < 16; s++)
			send_random_load(4'(s));
		drain();
		apply_setting(8'h10, 8'h5A);
		send_bare(MODE_INIT);
		repeat (8) send_bare(MODE_ALLOC);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
			0: apply_setting(8'hFF, 8'h00);
			1: apply_setting(8'h00, 8'hFF);
			2: apply_setting(8'h01, USED_MARK);
			3: apply_setting(8'h10, USED_MARK);
			4: apply_setting(8'h10, 8'hFF);
			default: apply_setting({3'($urandom), 5'($urandom_range(1, 20))}, 8'($urandom));
			endcase
			run_phase((p == 1) ? 60 : PHASE_WORDS);
		end

		repeat (40) @(posedge clk);
		$display("Sent %0d loads, %0d inits, %0d allocations and %0d unused-mode words under %0d register settings.",
			mode_tally[0], mode_tally[1], mode_tally[2], mode_tally[3], settings_used);
		$display("Frames handed out: %0d; out-of-memory answers: %0d.", frames_given, oom_answers);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Response side: random stalls, stretches without any, and two long hold-offs that
	// back the allocator up into its request channel.
	initial begin : response_side
		int unsigned taken;
		int unsigned stall;
		bit stalls_on;
		taken = 0;
		stalls_on = 1'b1;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (taken == 250 || taken == 900) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (taken % 60 == 0)
					stalls_on = ($urandom_range(0, 2) != 0);
				stall = stalls_on ? $urandom_range(0, 14) : 0;
				if (stall != 0) begin
					rsp_ch.ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			taken++;
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("No word moved for %0d cycles, giving up.", STALL_LIMIT);
		$display("Test completed with failures");
		$finish;
	end
endmodule
